// ===== src/pps_pkg.sv =====
// Package for the preemptive priority scheduler with aging.
// Holds the slot status codes, the sequencer states and reset constants.
// Depends on nothing.
package pps_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [3:0] AGING_PERIOD_RST = 4'd3;
    localparam logic [3:0] IO_BOOST_RST     = 4'd2;
    localparam logic [3:0] CPU_BOOST_RST    = 4'd1;

    localparam logic [1:0] CFG_AGING_PERIOD = 2'd0;
    localparam logic [1:0] CFG_IO_BOOST     = 2'd1;
    localparam logic [1:0] CFG_CPU_BOOST    = 2'd2;

    typedef enum logic [2:0] {
        ST_EMPTY   = 3'd0,
        ST_READY   = 3'd1,
        ST_RUNNING = 3'd2,
        ST_BLOCKED = 3'd3,
        ST_DONE    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RETIRE,
        S_SCAN,
        S_PICK,
        S_AGE,
        S_OUT
    } t_state;

    // Per-slot record kept in the task memory.
    typedef struct packed {
        logic [15:0] order;
        logic [15:0] remaining;
        logic [7:0]  blocks_left;
        logic        io_class;
        logic [15:0] arrival;
        logic [7:0]  wait_cnt;
    } t_task;

endpackage

// ===== src/preemptive_priority_scheduler_aging.sv =====
// Top level of the preemptive priority scheduler with aging.
// Uses pps_pkg for status codes, sequencer states and the task record.
//
// The block keeps up to SLOTS tasks. An add item is taken in the idle state
// and goes straight to the output state. A tick item walks the task memory
// twice, once to find the best ready task and once to age the waiting tasks,
// one slot at a time through the single read port of the task memory; no new
// item is taken until the sequencer is back in idle. Status, priority and
// started flags sit in flip-flops so that reset empties the table at once;
// the remaining task fields live in a one-port-read memory with registered
// read data. One result item is produced per input item. While the receiver
// stalls, the result waits in the output register; the next input item is
// still taken, and the sequencer then holds in its final state until the
// waiting result has gone.
module preemptive_priority_scheduler_aging #(
    parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [3:0]  i_slot,
    input  logic [7:0]  i_start_priority,
    input  logic        i_is_io_task,
    input  logic [15:0] i_work_units,
    input  logic [7:0]  i_block_budget,
    input  logic        i_block_now,
    input  logic [15:0] i_unblock_mask,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_running_valid,
    output logic [3:0]  o_running_slot,
    output logic        o_finished_valid,
    output logic [3:0]  o_finished_slot,
    output logic [15:0] o_turnaround,
    output logic        o_first_run,
    output logic [15:0] o_response_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int SW = $clog2(SLOTS);

    // Configuration registers.
    logic [3:0] r_aging_period, r_io_boost, r_cpu_boost;

    // Flip-flop held per-slot state.
    pps_pkg::t_status    r_status [SLOTS];
    logic [7:0]          r_prio   [SLOTS];
    logic [SLOTS-1:0]    r_started;

    // Task memory.
    pps_pkg::t_task      mem [SLOTS];
    pps_pkg::t_task      r_rd;
    logic                mem_we;
    logic [SW-1:0]       mem_wa, mem_ra;
    pps_pkg::t_task      mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    pps_pkg::t_state r_state, n_state;
    logic [15:0] r_time, r_next_order;
    logic        r_run_vld;
    logic [SW-1:0] r_run;
    logic        r_blk, r_fin_vld;
    logic [SW-1:0] r_fin;
    logic [15:0] r_turn;
    logic [15:0] r_mask;
    logic [SW:0] r_idx;          // scan counter, also holds SLOTS
    logic        r_best_vld;
    logic [SW-1:0] r_best;
    logic [7:0]  r_best_prio;
    logic [15:0] r_best_order;
    logic [15:0] r_run_order;    // order of running task, captured in retire
    logic        r_out_vld;
    logic [SW-1:0] r_ag_prev;    // slot being aged with read data in r_rd
    logic        r_first;        // running task started during this tick
    logic [15:0] r_resp;
    // Tick flag and preemption record.
    logic          r_action_tick;
    logic          r_pre_vld;
    logic [SW-1:0] r_prev_pre;

    assign o_cfg_ready = (r_state == pps_pkg::S_IDLE) && !r_out_vld;
    assign o_stall     = (r_state != pps_pkg::S_IDLE);
    assign o_valid     = r_out_vld;

    wire in_acc   = i_valid && !o_stall;
    wire out_free = !r_out_vld || !i_stall;
    wire [SW-1:0] idx_s = r_idx[SW-1:0];
    wire slot_ok  = (32'(i_slot) < SLOTS);
    wire [SW-1:0] add_slot = SW'(i_slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pps_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = i_action ? pps_pkg::S_RETIRE : pps_pkg::S_OUT;
                end
            end
            pps_pkg::S_RETIRE: n_state = pps_pkg::S_SCAN;
            pps_pkg::S_SCAN: begin
                if (r_idx == (SW+1)'(SLOTS)) n_state = pps_pkg::S_PICK;
            end
            pps_pkg::S_PICK: n_state = pps_pkg::S_AGE;
            pps_pkg::S_AGE: begin
                if (r_idx == (SW+1)'(SLOTS)) n_state = pps_pkg::S_OUT;
            end
            pps_pkg::S_OUT: begin
                if (out_free) n_state = pps_pkg::S_IDLE;
            end
            default: n_state = pps_pkg::S_IDLE;
        endcase
    end

    // Memory address selection. Once a pass has ended the counter rests at
    // SLOTS, and the address falls back to slot zero ready for the next pass.
    always_comb begin
        mem_ra = (r_idx < (SW+1)'(SLOTS)) ? idx_s : '0;
        if (r_state == pps_pkg::S_IDLE) mem_ra = r_run;
        if (r_state == pps_pkg::S_PICK) mem_ra = '0;
    end

    logic        retire_fin, retire_blk;
    logic [3:0]  boost;
    logic [8:0]  boosted;
    logic [7:0]  wait_base;
    logic [8:0]  wait_inc;
    logic [3:0]  period;
    logic        cand_better;

    always_comb begin
        retire_fin = r_run_vld && (r_rd.remaining == 16'd0);
        retire_blk = r_run_vld && !retire_fin && r_rd.io_class &&
                     (r_rd.blocks_left != 8'd0) && r_blk;
        period   = (r_aging_period == 4'd0) ? 4'd1 : r_aging_period;
        boost    = r_rd.io_class ? r_io_boost : r_cpu_boost;
        boosted  = {1'b0, r_prio[r_ag_prev]} + {5'd0, boost};
        // A task preempted in this tick starts its waiting count afresh.
        wait_base = (r_pre_vld && r_ag_prev == r_prev_pre) ? 8'd0 : r_rd.wait_cnt;
        wait_inc = {1'b0, wait_base} + 9'd1;
        cand_better = !r_best_vld || (r_prio[r_ag_prev] > r_best_prio) ||
                      ((r_prio[r_ag_prev] == r_best_prio) &&
                       (r_rd.order < r_best_order));
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ag_prev;
        mem_wd = r_rd;
        if (r_state == pps_pkg::S_IDLE && in_acc && !i_action && slot_ok) begin
            mem_we = 1'b1;
            mem_wa = add_slot;
            mem_wd.order       = r_next_order;
            mem_wd.remaining   = i_work_units;
            mem_wd.blocks_left = i_block_budget;
            mem_wd.io_class    = i_is_io_task;
            mem_wd.arrival     = r_time;
            mem_wd.wait_cnt    = 8'd0;
        end else if (r_state == pps_pkg::S_RETIRE && retire_blk) begin
            mem_we = 1'b1;
            mem_wa = r_run;
            mem_wd.blocks_left = r_rd.blocks_left - 8'd1;
        end else if (r_state == pps_pkg::S_AGE && r_idx != '0) begin
            mem_we = 1'b1;
            if (r_status[r_ag_prev] == pps_pkg::ST_READY) begin
                mem_wd.wait_cnt = (wait_inc >= {5'd0, period}) ? 8'd0 : wait_inc[7:0];
            end
            if (r_run_vld && r_ag_prev == r_run && r_rd.remaining != 16'd0) begin
                mem_wd.remaining = r_rd.remaining - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_period <= pps_pkg::AGING_PERIOD_RST;
            r_io_boost     <= pps_pkg::IO_BOOST_RST;
            r_cpu_boost    <= pps_pkg::CPU_BOOST_RST;
            for (int i = 0; i < SLOTS; i++) begin
                r_status[i] <= pps_pkg::ST_EMPTY;
                r_prio[i]   <= 8'd0;
            end
            r_started    <= '0;
            r_time       <= '0;
            r_next_order <= '0;
            r_run_vld    <= 1'b0;
            r_run        <= '0;
            r_out_vld    <= 1'b0;
            r_idx        <= '0;
            r_best_vld   <= 1'b0;
            r_ag_prev    <= '0;
            r_pre_vld    <= 1'b0;
            r_first      <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pps_pkg::CFG_AGING_PERIOD: r_aging_period <= i_cfg_data;
                    pps_pkg::CFG_IO_BOOST:     r_io_boost     <= i_cfg_data;
                    pps_pkg::CFG_CPU_BOOST:    r_cpu_boost    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == pps_pkg::S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                pps_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_blk   <= i_block_now;
                        r_mask  <= i_unblock_mask;
                        r_first <= 1'b0;
                        if (!i_action && slot_ok) begin
                            if (r_run_vld && r_run == add_slot) r_run_vld <= 1'b0;
                            r_status[add_slot]  <= pps_pkg::ST_READY;
                            r_prio[add_slot]    <= i_start_priority;
                            r_started[add_slot] <= 1'b0;
                            r_next_order <= r_next_order + 16'd1;
                        end
                    end
                end
                pps_pkg::S_RETIRE: begin
                    r_run_order <= r_rd.order;
                    if (retire_fin) begin
                        r_fin_vld <= 1'b1;
                        r_fin     <= r_run;
                        r_turn    <= r_time - r_rd.arrival;
                        r_status[r_run] <= pps_pkg::ST_DONE;
                        r_run_vld <= 1'b0;
                    end else begin
                        r_fin_vld <= 1'b0;
                        if (retire_blk) begin
                            r_status[r_run] <= pps_pkg::ST_BLOCKED;
                            r_run_vld <= 1'b0;
                        end
                    end
                    r_idx      <= (SW+1)'(1);
                    r_ag_prev  <= '0;
                    r_best_vld <= 1'b0;
                    r_pre_vld  <= 1'b0;
                end
                pps_pkg::S_SCAN: begin
                    // r_rd holds the record of slot r_ag_prev.
                    if (r_status[r_ag_prev] == pps_pkg::ST_READY && cand_better) begin
                        r_best_vld   <= 1'b1;
                        r_best       <= r_ag_prev;
                        r_best_prio  <= r_prio[r_ag_prev];
                        r_best_order <= r_rd.order;
                    end
                    if (r_idx != (SW+1)'(SLOTS)) begin
                        r_ag_prev <= idx_s;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                pps_pkg::S_PICK: begin
                    if (r_best_vld) begin
                        if (!r_run_vld) begin
                            r_status[r_best] <= pps_pkg::ST_RUNNING;
                            r_run     <= r_best;
                            r_run_vld <= 1'b1;
                        end else if ((r_best_prio > r_prio[r_run]) ||
                                     ((r_best_prio == r_prio[r_run]) &&
                                      (r_best_order < r_run_order))) begin
                            // Preempted task goes back to ready; its wait
                            // count is cleared during the ageing pass.
                            r_status[r_run]  <= pps_pkg::ST_READY;
                            r_status[r_best] <= pps_pkg::ST_RUNNING;
                            r_run   <= r_best;
                            r_prev_pre <= r_run;
                            r_pre_vld  <= 1'b1;
                        end
                    end
                    r_idx     <= (SW+1)'(1);
                    r_ag_prev <= '0;
                end
                pps_pkg::S_AGE: begin
                    if (r_status[r_ag_prev] == pps_pkg::ST_READY &&
                        wait_inc >= {5'd0, period}) begin
                        r_prio[r_ag_prev] <= boosted[8] ? 8'hFF : boosted[7:0];
                    end
                    if (r_run_vld && r_ag_prev == r_run && !r_started[r_run]) begin
                        r_started[r_run] <= 1'b1;
                        r_first          <= 1'b1;
                        r_resp           <= r_time - r_rd.arrival;
                    end
                    if (r_idx != (SW+1)'(SLOTS)) begin
                        r_ag_prev <= idx_s;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                pps_pkg::S_OUT: begin
                    if (out_free) begin
                        if (r_action_tick) begin
                            o_running_valid  <= r_run_vld;
                            o_running_slot   <= r_run_vld ? 4'(r_run) : 4'd0;
                            o_finished_valid <= r_fin_vld;
                            o_finished_slot  <= r_fin_vld ? 4'(r_fin) : 4'd0;
                            o_turnaround     <= r_fin_vld ? r_turn : 16'd0;
                            o_first_run      <= r_first;
                            o_response_time  <= r_first ? r_resp : 16'd0;
                            for (int i = 0; i < SLOTS && i < 16; i++) begin
                                if (r_mask[i] && r_status[i] == pps_pkg::ST_BLOCKED)
                                    r_status[i] <= pps_pkg::ST_READY;
                            end
                            if (r_time != 16'hFFFF) r_time <= r_time + 16'd1;
                        end else begin
                            o_running_valid  <= 1'b0;
                            o_running_slot   <= '0;
                            o_finished_valid <= 1'b0;
                            o_finished_slot  <= '0;
                            o_turnaround     <= '0;
                            o_first_run      <= 1'b0;
                            o_response_time  <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_tick <= 1'b0;
        end else if (in_acc) begin
            r_action_tick <= i_action;
        end
    end

    // Assertions.
    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pps_pkg::S_OUT && r_run_vld) |->
        (r_status[r_run] == pps_pkg::ST_RUNNING))
        else $error("running slot not marked running");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_running_slot) &&
                                  $stable(o_turnaround) && $stable(o_response_time)))
        else $error("stalled result changed");
    a_fin_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished_valid && o_running_valid) |->
        (o_finished_slot != o_running_slot))
        else $error("finished task still running");

endmodule

// ===== verif/tb_preemptive_priority_scheduler_aging.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the preemptive priority scheduler with aging.
// Depends on pps_pkg and the preemptive_priority_scheduler_aging top level.
module tb_preemptive_priority_scheduler_aging;

    localparam int NSLOT = 16;
    localparam int NONE  = NSLOT;
    localparam int CYCLE_LIMIT = 600000;

    // One input item as the sender offers it.
    typedef struct packed {
        logic        action;
        logic [3:0]  slot;
        logic [7:0]  prio;
        logic        io;
        logic [15:0] work;
        logic [7:0]  budget;
        logic        blk;
        logic [15:0] mask;
    } t_item;

    // One result item: what ran, what finished, and the timing figures.
    typedef struct packed {
        logic        run_v;
        logic [3:0]  run_slot;
        logic        fin_v;
        logic [3:0]  fin_slot;
        logic [15:0] turnaround;
        logic        first;
        logic [15:0] response;
    } t_sched;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b1;
    logic cfg_valid = 1'b0;
    logic [1:0] cfg_index = pps_pkg::CFG_AGING_PERIOD;
    logic [3:0] cfg_data = 4'd0;
    t_item cur = '0;

    logic o_stall, o_valid, o_cfg_ready;
    logic o_running_valid, o_finished_valid, o_first_run;
    logic [3:0] o_running_slot, o_finished_slot;
    logic [15:0] o_turnaround, o_response_time;

    preemptive_priority_scheduler_aging u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(o_stall),
        .i_action(cur.action), .i_slot(cur.slot), .i_start_priority(cur.prio),
        .i_is_io_task(cur.io), .i_work_units(cur.work), .i_block_budget(cur.budget),
        .i_block_now(cur.blk), .i_unblock_mask(cur.mask),
        .o_valid(o_valid), .i_stall(out_stall),
        .o_running_valid(o_running_valid), .o_running_slot(o_running_slot),
        .o_finished_valid(o_finished_valid), .o_finished_slot(o_finished_slot),
        .o_turnaround(o_turnaround), .o_first_run(o_first_run),
        .o_response_time(o_response_time),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Scheduler shadow state, kept in step with every accepted item.
    pps_pkg::t_status sh_status [NSLOT];
    logic [7:0]  sh_prio [NSLOT];
    logic [15:0] sh_order [NSLOT];
    logic [7:0]  sh_wait [NSLOT];
    logic [15:0] sh_left [NSLOT];
    logic [7:0]  sh_blocks [NSLOT];
    logic        sh_io [NSLOT];
    logic [15:0] sh_arrival [NSLOT];
    logic        sh_started [NSLOT];
    logic [15:0] sh_now = '0;
    logic [15:0] sh_next_order = '0;
    int          sh_running = NONE;
    logic [3:0]  aging_period = pps_pkg::AGING_PERIOD_RST;
    logic [3:0]  io_boost = pps_pkg::IO_BOOST_RST;
    logic [3:0]  cpu_boost = pps_pkg::CPU_BOOST_RST;

    t_item  pending_items [$];
    t_sched expected_sched [$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accepted_items = 0;
    int checked_results = 0;
    int finished_seen = 0;
    int blocks_seen = 0;
    int mismatches = 0;
    int cycles = 0;

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            sh_status[i] = pps_pkg::ST_EMPTY;
            sh_prio[i] = '0;
            sh_wait[i] = '0;
            sh_started[i] = 1'b0;
            sh_order[i] = '0;
            sh_left[i] = '0;
            sh_blocks[i] = '0;
            sh_io[i] = 1'b0;
            sh_arrival[i] = '0;
        end
    end

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Task a beats task b on higher priority, then on earlier arrival order.
    function automatic bit outranks(int a, int b);
        if (sh_prio[a] != sh_prio[b])
            return sh_prio[a] > sh_prio[b];
        return sh_order[a] < sh_order[b];
    endfunction

    function automatic int best_ready_slot();
        int best;
        best = NONE;
        for (int i = 0; i < NSLOT; i++)
            if (sh_status[i] == pps_pkg::ST_READY && (best == NONE || outranks(i, best)))
                best = i;
        return best;
    endfunction

    // Advances the shadow scheduler by one item and returns its result.
    function automatic t_sched schedule_step(t_item it);
        t_sched res;
        int c, r;
        int w, p;
        res = '0;
        if (!it.action) begin
            r = int'(it.slot);
            if (sh_running == r)
                sh_running = NONE;
            sh_status[r] = pps_pkg::ST_READY;
            sh_prio[r] = it.prio;
            sh_io[r] = it.io;
            sh_left[r] = it.work;
            sh_blocks[r] = it.budget;
            sh_arrival[r] = sh_now;
            sh_order[r] = sh_next_order;
            sh_next_order = sh_next_order + 16'd1;
            sh_wait[r] = '0;
            sh_started[r] = 1'b0;
            return res;
        end
        // Retire a finished task, or block an I/O task that asks to.
        if (sh_running != NONE) begin
            r = sh_running;
            if (sh_left[r] == 16'd0) begin
                res.fin_v = 1'b1;
                res.fin_slot = r[3:0];
                res.turnaround = sh_now - sh_arrival[r];
                sh_status[r] = pps_pkg::ST_DONE;
                sh_running = NONE;
            end else if (sh_io[r] && sh_blocks[r] > 8'd0 && it.blk) begin
                sh_status[r] = pps_pkg::ST_BLOCKED;
                sh_blocks[r] = sh_blocks[r] - 8'd1;
                sh_running = NONE;
                blocks_seen++;
            end
        end
        // Preempt only for a strictly better ready task.
        if (sh_running != NONE) begin
            c = best_ready_slot();
            if (c != NONE && outranks(c, sh_running)) begin
                sh_status[sh_running] = pps_pkg::ST_READY;
                sh_wait[sh_running] = '0;
                sh_status[c] = pps_pkg::ST_RUNNING;
                sh_running = c;
            end
        end
        if (sh_running == NONE) begin
            c = best_ready_slot();
            if (c != NONE) begin
                sh_status[c] = pps_pkg::ST_RUNNING;
                sh_running = c;
            end
        end
        // Aging: the boost lands every period-th waiting tick, saturating.
        for (int i = 0; i < NSLOT; i++) begin
            if (sh_status[i] == pps_pkg::ST_READY) begin
                w = int'(sh_wait[i]) + 1;
                if (w >= int'(aging_period)) begin
                    p = int'(sh_prio[i]) + int'(sh_io[i] ? io_boost : cpu_boost);
                    sh_prio[i] = (p > 255) ? 8'd255 : p[7:0];
                    w = 0;
                end
                sh_wait[i] = w[7:0];
            end
        end
        if (sh_running != NONE) begin
            r = sh_running;
            res.run_v = 1'b1;
            res.run_slot = r[3:0];
            if (sh_left[r] > 16'd0)
                sh_left[r] = sh_left[r] - 16'd1;
            if (!sh_started[r]) begin
                sh_started[r] = 1'b1;
                res.first = 1'b1;
                res.response = sh_now - sh_arrival[r];
            end
        end
        for (int i = 0; i < NSLOT; i++)
            if (it.mask[i] && sh_status[i] == pps_pkg::ST_BLOCKED)
                sh_status[i] = pps_pkg::ST_READY;
        if (sh_now != 16'hFFFF)
            sh_now = sh_now + 16'd1;
        return res;
    endfunction

    // Driver: the payload only moves on when the offered item was taken.
    always @(posedge i_clk) begin : sender
        bit may_load;
        may_load = !in_valid || !o_stall;
        if (i_rst_n) begin
            if (in_valid && !o_stall) begin
                expected_sched = {expected_sched, schedule_step(cur)};
                accepted_items++;
            end
            if (may_load) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall. Once, mid-run, it holds off for a long stretch so the
    // output register fills and the block has to refuse further items.
    int  hold_left = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && accepted_items >= 700) begin
            hold_done = 1;
            hold_left = 400;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: every result taken is compared with the oldest expectation.
    always @(posedge i_clk) begin : monitor
        t_sched got, want;
        if (i_rst_n && o_valid && !out_stall) begin
            got = {o_running_valid, o_running_slot, o_finished_valid, o_finished_slot,
                   o_turnaround, o_first_run, o_response_time};
            if (expected_sched.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: %p", got);
            end else begin
                want = expected_sched.pop_front();
                checked_results++;
                if (want.fin_v)
                    finished_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result %0d: expected %p, got %p",
                                 checked_results, want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_preemptive_priority_scheduler_aging: FAIL");
            $finish;
        end
    end

    function automatic t_item add_item(int s, int pr, bit io, int wk, int bud);
        t_item it;
        it = '0;
        it.action = 1'b0;
        it.slot = 4'(s);
        it.prio = 8'(pr);
        it.io = io;
        it.work = 16'(wk);
        it.budget = 8'(bud);
        return it;
    endfunction

    function automatic t_item tick_item(bit blk, int msk);
        t_item it;
        it = '0;
        it.action = 1'b1;
        it.blk = blk;
        it.mask = 16'(msk);
        return it;
    endfunction

    // Mostly short tasks with tied or close priorities, so that retirement,
    // blocking, preemption and aging all happen often; the rest is wide noise.
    function automatic t_item random_item();
        t_item it;
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        it = noise[$bits(t_item)-1:0];
        if ($urandom_range(99) < 25) begin
            it.action = 1'b0;
            if ($urandom_range(1) != 0) it.prio = 8'($urandom_range(140, 100));
            case ($urandom_range(19))
                0:       it.work = 16'd0;
                1, 2:    it.work = 16'($urandom);
                default: it.work = 16'($urandom_range(12, 1));
            endcase
            if ($urandom_range(9) < 7) it.budget = 8'($urandom_range(3));
        end else begin
            it.action = 1'b1;
            it.blk = ($urandom_range(99) < 40);
            case ($urandom_range(9))
                0:                it.mask = 16'($urandom);
                1, 2, 3:          it.mask = 16'd1 << $urandom_range(15);
                default:          it.mask = 16'd0;
            endcase
        end
        return it;
    endfunction

    function automatic void enqueue(t_item it);
        pending_items = {pending_items, it};
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_sched.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            pps_pkg::CFG_AGING_PERIOD: aging_period = val;
            pps_pkg::CFG_IO_BOOST:     io_boost = val;
            pps_pkg::CFG_CPU_BOOST:    cpu_boost = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at reset settings: extremes, ties, zero work,
        // blocking, overwriting the running slot and mask noise.
        send_idle_pct = 21;
        recv_idle_pct = 75;
        enqueue(add_item(0, 255, 1, 1, 255));
        enqueue(add_item(15, 0, 0, 65535, 0));
        enqueue(tick_item(1, 0));
        enqueue(tick_item(0, 16'hFFFF));
        enqueue(add_item(3, 0, 0, 0, 0));
        enqueue(add_item(5, 100, 1, 3, 2));
        enqueue(add_item(6, 100, 0, 3, 0));
        enqueue(tick_item(0, 0));
        enqueue(tick_item(1, 0));
        enqueue(tick_item(1, 16'h0020));
        enqueue(tick_item(0, 16'hFFFF));
        enqueue(add_item(6, 255, 1, 2, 1));
        enqueue(tick_item(0, 0));
        enqueue(add_item(6, 10, 0, 4, 0));
        for (int i = 0; i < 8; i++)
            enqueue(tick_item(i[0], 16'hFFFF));
        wait_idle();

        // Random phases, each under its own register settings; the pause
        // before each one lets every expected result come home first.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(pps_pkg::CFG_AGING_PERIOD, 4'd1);
                         write_reg(pps_pkg::CFG_IO_BOOST, 4'd15);
                         write_reg(pps_pkg::CFG_CPU_BOOST, 4'd15); end
                1: begin write_reg(pps_pkg::CFG_AGING_PERIOD, 4'd15);
                         write_reg(pps_pkg::CFG_IO_BOOST, 4'd0);
                         write_reg(pps_pkg::CFG_CPU_BOOST, 4'd0); end
                2: begin write_reg(pps_pkg::CFG_AGING_PERIOD, 4'd2);
                         write_reg(pps_pkg::CFG_IO_BOOST, 4'd0);
                         write_reg(pps_pkg::CFG_CPU_BOOST, 4'd15); end
                3: begin write_reg(pps_pkg::CFG_AGING_PERIOD, 4'($urandom_range(15, 1)));
                         write_reg(pps_pkg::CFG_IO_BOOST, 4'($urandom_range(15)));
                         write_reg(pps_pkg::CFG_CPU_BOOST, 4'($urandom_range(15))); end
                default: begin write_reg(pps_pkg::CFG_AGING_PERIOD, pps_pkg::AGING_PERIOD_RST);
                         write_reg(pps_pkg::CFG_IO_BOOST, pps_pkg::IO_BOOST_RST);
                         write_reg(pps_pkg::CFG_CPU_BOOST, pps_pkg::CPU_BOOST_RST); end
            endcase
            send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 75 : 0;
            recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 21 : 0;
            for (int i = 0; i < 385; i++)
                enqueue(random_item());
            wait_idle();
        end

        $display("covered %0d items, %0d results checked, %0d completions, %0d blocks,",
                 accepted_items, checked_results, finished_seen, blocks_seen);
        $display("five register settings and a long output hold-off; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb_preemptive_priority_scheduler_aging: PASS");
        else
            $display("tb_preemptive_priority_scheduler_aging: FAIL");
        $finish;
    end

endmodule

// ===== preemptive_priority_scheduler_aging.f =====
src/pps_pkg.sv
src/preemptive_priority_scheduler_aging.sv
verif/tb_preemptive_priority_scheduler_aging.sv
